// ----- src/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg: serpentine scan sequencer shared definitions
// Widths, register indexes, command codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int RANGE_BITS = 20;   // width of ranges, frame counts and indexes
  localparam int CFG_W      = 20;   // widest configuration register
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_W    = 16;
  localparam int STEP_W     = 16;
  localparam int CNT_W      = $clog2(RANGE_BITS);

  // floor(v / 3) == (v * RECIP_THIRD) >> RECIP_SHIFT for every v below 2^17
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_THIRD = 43691;
  localparam int PROD_W      = FRAME_W + 1 + RECIP_SHIFT;

  typedef logic [RANGE_BITS-1:0] rng_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_RANGE_X      = 3'd2,
    CFG_RANGE_Y      = 3'd3,
    CFG_X_DIR_INIT   = 3'd4,
    CFG_Y_DIR_INIT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_SHOOT  = 2'd0,
    ACT_MOVE_Y = 2'd1,
    ACT_MOVE_X = 2'd2,
    ACT_IDLE   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    PH_SHOOT     = 2'd0,
    PH_MOVE_Y    = 2'd1,
    PH_ROW_SHOOT = 2'd2,
    PH_MOVE_X    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_STEP = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } state_e;

  typedef struct packed {
    logic accept;      // latch the request
    logic step_load;   // register step sizes, load dividers
    logic div_step;    // one quotient bit on both axes
    logic emit;        // produce the command, advance scan state
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// ----- src/serpentine_scan_sequencer.sv -----
// ----------------------------------------------------------------------------
// serpentine_scan_sequencer: serpentine stage scan command generator
//
// Input channel (in_valid_i/in_ready_o) carries one request: start_req_i = 1
// starts a new scan from the current config registers, 0 asks for the next
// command. Output channel (out_valid_o/out_ready_i) returns exactly one
// command per request: action, step count, direction and last flag.
// Config registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while no request is in flight, the block does not enforce it.
// A next-command request goes straight to command issue. A start request first
// registers the step sizes (reciprocal multiply), then runs RANGE_BITS (20)
// quotient bits through the bit-serial frame count dividers, then the command
// is issued. One request is in flight at a time; the next is accepted the cycle
// after the command enters the output register.
// If the receiver stalls, the finished command waits in the output register and
// the next request is taken but held until that register drains.
// Reset clears the config registers and ends any scan: requests then return
// idle until a start request arrives.
// ----------------------------------------------------------------------------
module serpentine_scan_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          start_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    action_o,
  output logic [sss_pkg::STEP_W-1:0]    step_count_o,
  output logic                          direction_o,
  output logic                          last_o
);

  sss_pkg::cmd_t  cmd;
  sss_pkg::stat_t stat;

  sss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .start_req_i (start_req_i),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_req_i  (start_req_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .step_count_o (step_count_o),
    .direction_o  (direction_o),
    .last_o       (last_o)
  );

endmodule

// ----- src/sss_div.sv -----
// ----------------------------------------------------------------------------
// sss_div: restoring divider, one quotient bit per cycle while step_i is high
// Quotient register holds the result after RANGE_BITS steps.
// ----------------------------------------------------------------------------
module sss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       step_i,
  input  sss_pkg::rng_t              dividend_i,
  input  logic [sss_pkg::STEP_W-1:0] divisor_i,
  output sss_pkg::rng_t              quotient_o
);

  sss_pkg::rng_t              quo_q, quo_d;
  logic [sss_pkg::STEP_W-1:0] rem_q, rem_d;
  logic [sss_pkg::STEP_W:0]   trial;
  logic                       fits;

  assign trial = {rem_q, quo_q[sss_pkg::RANGE_BITS-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      quo_d = {quo_q[sss_pkg::RANGE_BITS-2:0], fits};
      rem_d = fits ? sss_pkg::STEP_W'(trial - {1'b0, divisor_i})
                   : sss_pkg::STEP_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= '0;
      rem_q <= '0;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

// ----- src/sss_dp.sv -----
// ----------------------------------------------------------------------------
// sss_dp: scan sequencer datapath
// Config registers, step size and frame count setup, scan position and the
// output register.
// ----------------------------------------------------------------------------
module sss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          start_req_i,
  input  sss_pkg::cmd_t                 cmd_i,
  output sss_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    action_o,
  output logic [sss_pkg::STEP_W-1:0]    step_count_o,
  output logic                          direction_o,
  output logic                          last_o
);

  // configuration
  logic [sss_pkg::FRAME_W-1:0] frame_w_q, frame_h_q;
  sss_pkg::rng_t               range_x_q, range_y_q;
  logic                        x_dir_q, y_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= '0;
      frame_h_q <= '0;
      range_x_q <= '0;
      range_y_q <= '0;
      x_dir_q   <= 1'b0;
      y_dir_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (sss_pkg::cfg_idx_e'(cfg_idx_i))
        sss_pkg::CFG_FRAME_WIDTH:  frame_w_q <= cfg_data_i[sss_pkg::FRAME_W-1:0];
        sss_pkg::CFG_FRAME_HEIGHT: frame_h_q <= cfg_data_i[sss_pkg::FRAME_W-1:0];
        sss_pkg::CFG_RANGE_X:      range_x_q <= sss_pkg::rng_t'(cfg_data_i);
        sss_pkg::CFG_RANGE_Y:      range_y_q <= sss_pkg::rng_t'(cfg_data_i);
        sss_pkg::CFG_X_DIR_INIT:   x_dir_q   <= cfg_data_i[0];
        sss_pkg::CFG_Y_DIR_INIT:   y_dir_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // step size = max(1, floor(2 * frame / 3)) via reciprocal multiply
  logic [sss_pkg::PROD_W-1:0] x_prod, y_prod;
  logic [sss_pkg::STEP_W-1:0] x_third, y_third;
  logic [sss_pkg::STEP_W-1:0] x_step_q, y_step_q;

  assign x_prod  = sss_pkg::PROD_W'({frame_w_q, 1'b0})
                 * sss_pkg::PROD_W'(sss_pkg::RECIP_THIRD);
  assign y_prod  = sss_pkg::PROD_W'({frame_h_q, 1'b0})
                 * sss_pkg::PROD_W'(sss_pkg::RECIP_THIRD);
  assign x_third = x_prod[sss_pkg::RECIP_SHIFT +: sss_pkg::STEP_W];
  assign y_third = y_prod[sss_pkg::RECIP_SHIFT +: sss_pkg::STEP_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_load) begin
      x_step_q <= (x_third == '0) ? sss_pkg::STEP_W'(1) : x_third;
      y_step_q <= (y_third == '0) ? sss_pkg::STEP_W'(1) : y_third;
    end
  end

  // frame counts
  sss_pkg::rng_t x_cnt, y_cnt;

  sss_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.step_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (range_x_q),
    .divisor_i  (x_step_q),
    .quotient_o (x_cnt)
  );

  sss_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.step_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (range_y_q),
    .divisor_i  (y_step_q),
    .quotient_o (y_cnt)
  );

  logic [sss_pkg::CNT_W-1:0] div_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.step_load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + sss_pkg::CNT_W'(1);
    end
  end

  assign stat_o.div_last = (div_cnt_q == sss_pkg::CNT_W'(sss_pkg::RANGE_BITS - 1));

  // scan state
  logic            start_q;
  logic            active_q, active_d;
  sss_pkg::phase_e phase_q, phase_d;
  sss_pkg::rng_t   col_q, col_d, row_q, row_d;
  logic            ydir_q, ydir_d;

  // effective state: a start request restarts the scan before it is stepped
  logic            eff_active, eff_ydir;
  sss_pkg::phase_e eff_phase;
  sss_pkg::rng_t   eff_col, eff_row, row_inc;

  sss_pkg::act_e               act;
  logic [sss_pkg::STEP_W-1:0]  steps;
  logic                        dir, lst;

  assign eff_active = start_q | active_q;
  assign eff_phase  = start_q ? sss_pkg::PH_SHOOT : phase_q;
  assign eff_col    = start_q ? '0 : col_q;
  assign eff_row    = start_q ? '0 : row_q;
  assign eff_ydir   = start_q ? y_dir_q : ydir_q;
  assign row_inc    = eff_row + sss_pkg::rng_t'(1);

  always_comb begin
    act      = sss_pkg::ACT_IDLE;
    steps    = '0;
    dir      = 1'b0;
    lst      = 1'b0;
    active_d = eff_active;
    phase_d  = eff_phase;
    col_d    = eff_col;
    row_d    = eff_row;
    ydir_d   = eff_ydir;
    if (eff_active) begin
      case (eff_phase)
        sss_pkg::PH_SHOOT: begin
          act = sss_pkg::ACT_SHOOT;
          if (eff_col >= x_cnt) begin
            lst      = 1'b1;
            active_d = 1'b0;
            phase_d  = sss_pkg::PH_SHOOT;
          end else begin
            row_d   = '0;
            phase_d = (y_cnt > sss_pkg::rng_t'(1)) ? sss_pkg::PH_MOVE_Y
                                                   : sss_pkg::PH_MOVE_X;
          end
        end
        sss_pkg::PH_MOVE_Y: begin
          act     = sss_pkg::ACT_MOVE_Y;
          steps   = y_step_q;
          dir     = eff_ydir;
          phase_d = sss_pkg::PH_ROW_SHOOT;
        end
        sss_pkg::PH_ROW_SHOOT: begin
          act     = sss_pkg::ACT_SHOOT;
          row_d   = row_inc;
          phase_d = (y_cnt > sss_pkg::rng_t'(1) &&
                     row_inc < y_cnt - sss_pkg::rng_t'(1)) ? sss_pkg::PH_MOVE_Y
                                                           : sss_pkg::PH_MOVE_X;
        end
        sss_pkg::PH_MOVE_X: begin
          act     = sss_pkg::ACT_MOVE_X;
          steps   = x_step_q;
          dir     = x_dir_q;
          ydir_d  = ~eff_ydir;
          col_d   = eff_col + sss_pkg::rng_t'(1);
          phase_d = sss_pkg::PH_SHOOT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b0;
      active_q <= 1'b0;
      phase_q  <= sss_pkg::PH_SHOOT;
      col_q    <= '0;
      row_q    <= '0;
      ydir_q   <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        start_q <= start_req_i;
      end
      if (cmd_i.emit) begin
        active_q <= active_d;
        phase_q  <= phase_d;
        col_q    <= col_d;
        row_q    <= row_d;
        ydir_q   <= ydir_d;
      end
    end
  end

  // output register
  logic                       out_valid_q;
  sss_pkg::act_e              act_q;
  logic [sss_pkg::STEP_W-1:0] steps_q;
  logic                       dir_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      act_q   <= act;
      steps_q <= steps;
      dir_q   <= dir;
      last_q  <= lst;
    end
  end

  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign action_o     = act_q;
  assign step_count_o = steps_q;
  assign direction_o  = dir_q;
  assign last_o       = last_q;

endmodule

// ----- src/sss_ctrl.sv -----
// ----------------------------------------------------------------------------
// sss_ctrl: scan sequencer controller
// Accepts requests and sequences setup, division and command issue.
// ----------------------------------------------------------------------------
module sss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           start_req_i,
  output logic           in_ready_o,
  input  sss_pkg::stat_t stat_i,
  output sss_pkg::cmd_t  cmd_o
);

  sss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = start_req_i ? sss_pkg::ST_STEP : sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_STEP: state_d = sss_pkg::ST_DIV;
      sss_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = sss_pkg::ST_IDLE;
        end
      end
      default: state_d = sss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      sss_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      sss_pkg::ST_STEP: cmd_o.step_load = 1'b1;
      sss_pkg::ST_DIV:  cmd_o.div_step  = 1'b1;
      sss_pkg::ST_EMIT: cmd_o.emit      = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: serpentine scan sequencer testbench
// A directed table walks the corner cases: idle after reset, zero frame counts,
// full-scale frames, restarts in the middle of a scan. Random scans follow over
// four handshake pressure phases. Every command is checked against a scan
// model that the bench keeps itself, or against the table where a row gives one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 510;
  localparam int DIR_ROWS       = 41;

  typedef struct packed {
    sss_pkg::act_e              action;
    logic [sss_pkg::STEP_W-1:0] steps;
    logic                       dir;
    logic                       last;
  } scan_cmd_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_REQ,
    ROW_REQ_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    sss_pkg::cfg_idx_e         idx;
    logic [sss_pkg::CFG_W-1:0] data;
    logic                      start;
    scan_cmd_t                 want;
  } dir_row_t;

  localparam scan_cmd_t IDLE_CMD    = '{sss_pkg::ACT_IDLE, 16'd0, 1'b0, 1'b0};
  localparam scan_cmd_t LAST_SHOOT  = '{sss_pkg::ACT_SHOOT, 16'd0, 1'b0, 1'b1};
  localparam scan_cmd_t UNIT_MOVE_X = '{sss_pkg::ACT_MOVE_X, 16'd1, 1'b0, 1'b0};

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // out of reset: no scan, zero config gives a lone final shoot
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b1, LAST_SHOOT},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    // 2 columns x 2 rows, step 2 on both axes
    '{ROW_REG,       sss_pkg::CFG_FRAME_WIDTH,  20'd3,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_FRAME_HEIGHT, 20'd3,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_RANGE_X,      20'd4,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_RANGE_Y,      20'd5,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_X_DIR_INIT,   20'd1,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_Y_DIR_INIT,   20'd1,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b1, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, LAST_SHOOT},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    // full-scale frames and range; restart while the scan runs
    '{ROW_REG,       sss_pkg::CFG_FRAME_WIDTH,  20'd65535, 1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_FRAME_HEIGHT, 20'd65535, 1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_RANGE_X,      20'd43690, 1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_RANGE_Y,      20'hFFFFF, 1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_X_DIR_INIT,   20'd0,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_Y_DIR_INIT,   20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b1, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b1, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    // zero Y frame count: shoot and X move per column
    '{ROW_REG,       sss_pkg::CFG_RANGE_Y,      20'd43689, 1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_RANGE_X,      20'd87380, 1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b1, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, IDLE_CMD},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, LAST_SHOOT},
    // frame of 1 rounds to a step of 0, floored to 1
    '{ROW_REG,       sss_pkg::CFG_FRAME_WIDTH,  20'd1,     1'b0, IDLE_CMD},
    '{ROW_REG,       sss_pkg::CFG_RANGE_X,      20'd1,     1'b0, IDLE_CMD},
    '{ROW_REQ,       sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b1, IDLE_CMD},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, UNIT_MOVE_X},
    '{ROW_REQ_KNOWN, sss_pkg::CFG_FRAME_WIDTH,  20'd0,     1'b0, LAST_SHOOT}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [sss_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sss_pkg::CFG_W-1:0]     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          start_req_i;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [1:0]                    action_o;
  logic [sss_pkg::STEP_W-1:0]    step_count_o;
  logic                          direction_o;
  logic                          last_o;

  // scan model: register copies and sequencing state
  logic [sss_pkg::FRAME_W-1:0] reg_frame_w, reg_frame_h;
  sss_pkg::rng_t               reg_range_x, reg_range_y;
  logic                        reg_x_dir, reg_y_dir;
  logic                        scan_active;
  sss_pkg::phase_e             scan_phase;
  sss_pkg::rng_t               col_idx, row_idx, x_frames, y_frames;
  logic                        y_dir_cur;
  logic [sss_pkg::STEP_W-1:0]  x_step, y_step;

  scan_cmd_t   due_cmds [$];
  scan_cmd_t   seen_cmd, due_cmd;
  int unsigned mismatches   = 0;
  int unsigned reqs_done    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  serpentine_scan_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .step_count_o (step_count_o),
    .direction_o  (direction_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [sss_pkg::STEP_W-1:0] frame_step(
    input logic [sss_pkg::FRAME_W-1:0] frame
  );
    logic [sss_pkg::FRAME_W:0] third;
    third = {frame, 1'b0} / 3;
    return (third == 0) ? sss_pkg::STEP_W'(1) : third[sss_pkg::STEP_W-1:0];
  endfunction

  function automatic void store_reg(input sss_pkg::cfg_idx_e idx,
                                    input logic [sss_pkg::CFG_W-1:0] data);
    case (idx)
      sss_pkg::CFG_FRAME_WIDTH:  reg_frame_w = data[sss_pkg::FRAME_W-1:0];
      sss_pkg::CFG_FRAME_HEIGHT: reg_frame_h = data[sss_pkg::FRAME_W-1:0];
      sss_pkg::CFG_RANGE_X:      reg_range_x = data[sss_pkg::RANGE_BITS-1:0];
      sss_pkg::CFG_RANGE_Y:      reg_range_y = data[sss_pkg::RANGE_BITS-1:0];
      sss_pkg::CFG_X_DIR_INIT:   reg_x_dir   = data[0];
      sss_pkg::CFG_Y_DIR_INIT:   reg_y_dir   = data[0];
      default: ;
    endcase
  endfunction

  // next command of the serpentine scan for one request
  function automatic scan_cmd_t advance_scan(input logic start);
    scan_cmd_t cmd;
    cmd = '{sss_pkg::ACT_SHOOT, 16'd0, 1'b0, 1'b0};
    if (start) begin
      x_step      = frame_step(reg_frame_w);
      y_step      = frame_step(reg_frame_h);
      x_frames    = reg_range_x / x_step;
      y_frames    = reg_range_y / y_step;
      y_dir_cur   = reg_y_dir;
      col_idx     = '0;
      row_idx     = '0;
      scan_phase  = sss_pkg::PH_SHOOT;
      scan_active = 1'b1;
    end
    if (!scan_active) return IDLE_CMD;
    case (scan_phase)
      sss_pkg::PH_SHOOT: begin
        if (col_idx >= x_frames) begin
          cmd.last    = 1'b1;
          scan_active = 1'b0;
          scan_phase  = sss_pkg::PH_SHOOT;
        end else begin
          row_idx    = '0;
          scan_phase = (y_frames > 1) ? sss_pkg::PH_MOVE_Y : sss_pkg::PH_MOVE_X;
        end
      end
      sss_pkg::PH_MOVE_Y: begin
        cmd        = '{sss_pkg::ACT_MOVE_Y, y_step, y_dir_cur, 1'b0};
        scan_phase = sss_pkg::PH_ROW_SHOOT;
      end
      sss_pkg::PH_ROW_SHOOT: begin
        row_idx    = row_idx + 1'b1;
        scan_phase = (y_frames > 1 && row_idx < y_frames - 1) ? sss_pkg::PH_MOVE_Y
                                                              : sss_pkg::PH_MOVE_X;
      end
      default: begin
        cmd        = '{sss_pkg::ACT_MOVE_X, x_step, reg_x_dir, 1'b0};
        y_dir_cur  = ~y_dir_cur;
        col_idx    = col_idx + 1'b1;
        scan_phase = sss_pkg::PH_SHOOT;
      end
    endcase
    return cmd;
  endfunction

  // called in the step of a rising edge; valid is left high after the accept
  task automatic issue_request(input logic start, input logic known = 1'b0,
                               input scan_cmd_t want = IDLE_CMD);
    scan_cmd_t model_cmd;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    model_cmd = advance_scan(start);
    due_cmds.push_back(known ? want : model_cmd);
    reqs_done++;
  endtask

  // registers change only with no request in flight
  task automatic write_reg(input sss_pkg::cfg_idx_e idx,
                           input logic [sss_pkg::CFG_W-1:0] data);
    in_valid_i <= 1'b0;
    while (due_cmds.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    store_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic logic [sss_pkg::FRAME_W-1:0] pick_frame();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return sss_pkg::FRAME_W'($urandom_range(1, 12));
    else if (r < 70) return '0;
    else if (r < 80) return '1;
    else return sss_pkg::FRAME_W'($urandom);
  endfunction

  // mostly a handful of frames along the axis, sometimes long or arbitrary
  function automatic logic [sss_pkg::CFG_W-1:0] pick_range(
    input logic [sss_pkg::STEP_W-1:0] step
  );
    int unsigned     r;
    longint unsigned v;
    r = $urandom_range(99);
    if (r < 65) v = 64'(step) * $urandom_range(0, 4) + $urandom_range(0, step - 1);
    else if (r < 80) v = 64'(step) * $urandom_range(5, 30);
    else if (r < 92) v = $urandom_range(0, 20'hFFFFF);
    else v = ($urandom_range(1) != 0) ? 20'hFFFFF : 0;
    if (v > 20'hFFFFF) v = 20'hFFFFF;
    return sss_pkg::CFG_W'(v);
  endfunction

  // unused upper data bits carry noise
  task automatic load_random_config();
    if ($urandom_range(4) != 0)
      write_reg(sss_pkg::CFG_FRAME_WIDTH, {4'($urandom), pick_frame()});
    if ($urandom_range(4) != 0)
      write_reg(sss_pkg::CFG_FRAME_HEIGHT, {4'($urandom), pick_frame()});
    if ($urandom_range(4) != 0)
      write_reg(sss_pkg::CFG_RANGE_X, pick_range(frame_step(reg_frame_w)));
    if ($urandom_range(4) != 0)
      write_reg(sss_pkg::CFG_RANGE_Y, pick_range(frame_step(reg_frame_h)));
    if ($urandom_range(4) != 0)
      write_reg(sss_pkg::CFG_X_DIR_INIT, {19'($urandom), 1'($urandom)});
    if ($urandom_range(4) != 0)
      write_reg(sss_pkg::CFG_Y_DIR_INIT, {19'($urandom), 1'($urandom)});
  endtask

  task automatic run_random_scan();
    int unsigned cap, n, extra;
    cap   = ($urandom_range(99) < 75) ? 150 : $urandom_range(1, 20);
    extra = ($urandom_range(99) < 30) ? $urandom_range(1, 2) : 0;
    if ($urandom_range(99) < 5) issue_request(1'b0);
    issue_request(1'b1);
    n = 0;
    // a rare start in the middle abandons the scan
    while (scan_active && n < cap) begin
      issue_request($urandom_range(99) < 2);
      n++;
    end
    repeat (extra) issue_request(1'b0);
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      seen_cmd = '{sss_pkg::act_e'(action_o), step_count_o, direction_o, last_o};
      if (due_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: command with no request pending at %0t: %s",
                   $time, $sformatf("act=%0d steps=%0d dir=%0d last=%0d",
                   seen_cmd.action, seen_cmd.steps, seen_cmd.dir, seen_cmd.last));
      end else begin
        due_cmd = due_cmds.pop_front();
        if (seen_cmd.action !== due_cmd.action || seen_cmd.steps !== due_cmd.steps ||
            seen_cmd.dir !== due_cmd.dir || seen_cmd.last !== due_cmd.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: command mismatch at %0t", $time);
            $display("tb:   exp act=%0d steps=%0d dir=%0d last=%0d",
                     due_cmd.action, due_cmd.steps, due_cmd.dir, due_cmd.last);
            $display("tb:   got act=%0d steps=%0d dir=%0d last=%0d",
                     seen_cmd.action, seen_cmd.steps, seen_cmd.dir, seen_cmd.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned base;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= sss_pkg::CFG_FRAME_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    start_req_i <= 1'b0;
    reg_frame_w = '0;
    reg_frame_h = '0;
    reg_range_x = '0;
    reg_range_y = '0;
    reg_x_dir   = 1'b0;
    reg_y_dir   = 1'b0;
    scan_active = 1'b0;
    scan_phase  = sss_pkg::PH_SHOOT;
    col_idx     = '0;
    row_idx     = '0;
    x_frames    = '0;
    y_frames    = '0;
    y_dir_cur   = 1'b0;
    x_step      = '0;
    y_step      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_REG)
        write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].data);
      else
        issue_request(DIR_TABLE[i].start, DIR_TABLE[i].kind == ROW_REQ_KNOWN,
                      DIR_TABLE[i].want);
    end

    // pressure phases: none, sender idle, receiver stall, both light
    base = reqs_done;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
        1: begin snd_idle_pct = 82; rcv_idle_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_idle_pct = 82; end
        default: begin snd_idle_pct = 13; rcv_idle_pct = 13; end
      endcase
      while (reqs_done < base + (ph + 1) * RANDOM_ITEMS / 4) begin
        load_random_config();
        run_random_scan();
      end
    end

    in_valid_i <= 1'b0;
    while (due_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_cmds.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sss_pkg.sv
src/sss_div.sv
src/sss_dp.sv
src/sss_ctrl.sv
src/serpentine_scan_sequencer.sv
tb/tb_top.sv
